FILE: rtl/core/tset_pkg.sv
package tset_pkg;

   // request kinds carried on req_tuser
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   // one stored event, time in the top bits
   typedef struct packed {
      logic [31:0] ev_time;
      logic [2:0]  kind;
      logic [3:0]  channel;
      logic [6:0]  key;
      logic [6:0]  velocity;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_ROTATE
   } cell_op_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      cell_op_type op;
      entry_type   entry;
   } cell_ctl_type;

endpackage

FILE: rtl/core/tset_cell.sv
module tset_cell
   import tset_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         occ,
   input  logic         prev_occ,
   input  entry_type    prev_entry,
   input  entry_type    next_entry,
   input  entry_type    head_entry,
   input  logic         wrap,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      less;
   logic      prev_less;

   always_comb begin
      less      = occ && (entry_ff.ev_time < ctl.entry.ev_time);
      prev_less = prev_occ && (prev_entry.ev_time < ctl.entry.ev_time);
      entry_in  = entry_ff;
      case (ctl.op)
         CELL_INSERT: begin
            // earlier events stay, the slot right after them takes the new one
            if (less) begin
               entry_in = entry_ff;
            end else if (prev_less) begin
               entry_in = ctl.entry;
            end else begin
               entry_in = prev_entry;
            end
         end
         CELL_ROTATE: begin
            entry_in = wrap ? head_entry : next_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: rtl/core/time_sorted_event_table.sv
// channel   dir  handshake          payload
// req       in   tvalid/tready      tuser: request kind, tdata: event and window
// rsp       out  tvalid/tready      tuser: found, table_full; tdata: event; tlast
//
// an insert takes the request, then shifts the cell row
// a query rotates the row once through cell 0, one entry a cycle, and each
// matching event leaves from cell 0
// a stalled response holds the rotation in place until it is taken
// reset empties the table (count to zero) and drops any pending response;
// the cell contents are not cleared
module time_sorted_event_table
   import tset_pkg::*;
#(
   parameter int DEPTH = 64
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // req_type
   input  logic         req_tuser,
   // event_time, event_kind, event_channel, event_key, event_velocity,
   // window_start, window_end, zero fill
   input  logic [119:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // found, table_full
   output logic [1:0]   rsp_tuser,
   // out_time, out_kind, out_channel, out_key, out_velocity, zero fill
   output logic [55:0]  rsp_tdata,
   output logic         rsp_tlast
);

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_QUERY
   } state_type;

   state_type state_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] step_ff;
   logic          found_any_ff;

   // latched request
   logic          req_kind_ff;
   entry_type     new_ff;
   logic [31:0]   win_start_ff;
   logic [31:0]   win_end_ff;

   // output register
   logic          rsp_valid_ff;
   logic [1:0]    rsp_user_ff;
   entry_type     rsp_entry_ff;
   logic          rsp_last_ff;

   cell_ctl_type  ctl;
   entry_type     cell_entry [DEPTH];
   logic [DEPTH-1:0] occ;
   logic [DEPTH-1:0] wrap;

   logic          rsp_free;
   logic          rsp_load;
   logic          head_match;
   logic          next_match;
   logic          final_step;
   logic          req_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // window test on the head cell and its successor
   assign head_match = (win_start_ff <= cell_entry[0].ev_time) &&
                       (cell_entry[0].ev_time <= win_end_ff);
   assign next_match = (win_start_ff <= cell_entry[1].ev_time) &&
                       (cell_entry[1].ev_time <= win_end_ff);
   assign final_step = (count_ff == '0) || (step_ff == count_ff - 1'b1);

   // a new response enters the output register this cycle
   assign rsp_load = rsp_free &&
                     ((state_ff == ST_INSERT) ||
                      (state_ff == ST_QUERY &&
                       ((count_ff != '0 && head_match) ||
                        (final_step && !found_any_ff))));

   always_comb begin
      ctl.entry = new_ff;
      ctl.op    = CELL_HOLD;
      if (rsp_free) begin
         if (state_ff == ST_INSERT && count_ff != CW'(DEPTH)) begin
            ctl.op = CELL_INSERT;
         end else if (state_ff == ST_QUERY && count_ff != '0) begin
            ctl.op = CELL_ROTATE;
         end
      end
   end

   // the row of cells; cell 0 is the earliest event
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign occ[i]  = CW'(i) < count_ff;
      assign wrap[i] = CW'(i) == (count_ff - 1'b1);

      if (i == 0) begin : g_first
         tset_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .occ        (occ[i]),
            .prev_occ   (1'b0),
            .prev_entry (new_ff),
            .next_entry (cell_entry[i+1]),
            .head_entry (cell_entry[0]),
            .wrap       (wrap[i]),
            .entry      (cell_entry[i])
         );
      end else if (i == DEPTH - 1) begin : g_last
         tset_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .occ        (occ[i]),
            .prev_occ   (occ[i-1]),
            .prev_entry (cell_entry[i-1]),
            .next_entry (cell_entry[0]),
            .head_entry (cell_entry[0]),
            .wrap       (wrap[i]),
            .entry      (cell_entry[i])
         );
      end else begin : g_mid
         tset_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .occ        (occ[i]),
            .prev_occ   (occ[i-1]),
            .prev_entry (cell_entry[i-1]),
            .next_entry (cell_entry[i+1]),
            .head_entry (cell_entry[0]),
            .wrap       (wrap[i]),
            .entry      (cell_entry[i])
         );
      end
   end

   // request payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_kind_ff           <= req_tuser;
         new_ff.ev_time        <= req_tdata[31:0];
         new_ff.kind           <= req_tdata[34:32];
         new_ff.channel        <= req_tdata[38:35];
         new_ff.key            <= req_tdata[45:39];
         new_ff.velocity       <= req_tdata[52:46];
         win_start_ff          <= req_tdata[84:53];
         win_end_ff            <= req_tdata[116:85];
      end
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         found_any_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  step_ff      <= '0;
                  found_any_ff <= 1'b0;
                  state_ff     <= (req_tuser == REQ_QUERY) ? ST_QUERY : ST_INSERT;
               end
            end
            ST_INSERT: begin
               if (rsp_free) begin
                  rsp_entry_ff <= '0;
                  rsp_last_ff  <= 1'b1;
                  if (count_ff == CW'(DEPTH)) begin
                     rsp_user_ff <= 2'b10;
                  end else begin
                     rsp_user_ff <= 2'b00;
                     count_ff    <= count_ff + 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_QUERY: begin
               if (rsp_free) begin
                  if (count_ff != '0 && head_match) begin
                     // matches are contiguous, so a miss next ends the run
                     rsp_user_ff  <= 2'b01;
                     rsp_entry_ff <= cell_entry[0];
                     rsp_last_ff  <= final_step || !next_match;
                     found_any_ff <= 1'b1;
                  end else if (final_step && !found_any_ff) begin
                     rsp_user_ff  <= 2'b00;
                     rsp_entry_ff <= '0;
                     rsp_last_ff  <= 1'b1;
                  end
                  step_ff <= step_ff + 1'b1;
                  if (final_step) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'b000, rsp_entry_ff.velocity, rsp_entry_ff.key,
                        rsp_entry_ff.channel, rsp_entry_ff.kind,
                        rsp_entry_ff.ev_time};

   // the table never holds more than its depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   // a dropped insert is only reported while the table is full
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> count_ff == CW'(DEPTH))
      else $error("table_full reported with room left");

   // full and found never come together, and full ends the request
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && !rsp_tuser[0])
      else $error("bad table_full response");

   // the rotation never runs past the stored entries
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_QUERY |-> (count_ff == '0) || (step_ff < count_ff))
      else $error("query step out of range");

   // a query leaves the count untouched
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_QUERY && $past(state_ff == ST_QUERY) |-> $stable(count_ff))
      else $error("count changed during query");

   // kind of the latched request agrees with the insert state it led to
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INSERT |-> req_kind_ff == REQ_INSERT)
      else $error("insert state without insert request");

endmodule

FILE: tb/event_table_checker.sv
module event_table_checker
   import tset_pkg::*;
#(
   parameter int DEPTH = 64
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic         req_tuser,
   input  logic [119:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [1:0]   rsp_tuser,
   input  logic [55:0]  rsp_tdata,
   input  logic         rsp_tlast,
   output int           fail_count,
   output int           pending_count,
   output int           stored_count,
   output int           dropped_count,
   output int           query_count,
   output int           match_count
);

   typedef struct packed {
      logic      found;
      logic      table_full;
      entry_type ev;
      logic      last;
   } response_type;

   // sorted shadow copy of the table
   entry_type    shadow_table [DEPTH];
   int           shadow_count = 0;
   response_type expected_responses [$];

   int fails     = 0;
   int stored    = 0;
   int dropped   = 0;
   int queries   = 0;
   int hit_total = 0;

   task automatic predict_request(input logic kind, input logic [119:0] payload);
      entry_type    ev;
      logic [31:0]  win_lo;
      logic [31:0]  win_hi;
      response_type resp;
      int           pos;
      int           hits;
      int           seen;
      ev.ev_time  = payload[31:0];
      ev.kind     = payload[34:32];
      ev.channel  = payload[38:35];
      ev.key      = payload[45:39];
      ev.velocity = payload[52:46];
      win_lo      = payload[84:53];
      win_hi      = payload[116:85];
      resp        = '0;
      if (kind == REQ_INSERT) begin
         resp.last = 1'b1;
         if (shadow_count >= DEPTH) begin
            resp.table_full = 1'b1;
            dropped++;
         end else begin
            // lower bound: ahead of every entry with the same time
            pos = 0;
            while (pos < shadow_count && shadow_table[pos].ev_time < ev.ev_time)
               pos++;
            for (int i = shadow_count; i > pos; i--)
               shadow_table[i] = shadow_table[i - 1];
            shadow_table[pos] = ev;
            shadow_count++;
            stored++;
         end
         expected_responses.push_back(resp);
      end else begin
         queries++;
         hits = 0;
         for (int i = 0; i < shadow_count; i++)
            if (shadow_table[i].ev_time >= win_lo && shadow_table[i].ev_time <= win_hi)
               hits++;
         if (hits == 0) begin
            resp.last = 1'b1;
            expected_responses.push_back(resp);
         end else begin
            seen = 0;
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_table[i].ev_time >= win_lo && shadow_table[i].ev_time <= win_hi) begin
                  seen++;
                  resp.found = 1'b1;
                  resp.ev    = shadow_table[i];
                  resp.last  = (seen == hits);
                  expected_responses.push_back(resp);
               end
            end
            hit_total += hits;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fails++;
      end
   endtask

   task automatic compare_response();
      response_type want;
      if (expected_responses.size() == 0) begin
         $error("response with no request waiting: tuser %b tdata %h tlast %b",
                rsp_tuser, rsp_tdata, rsp_tlast);
         fails++;
      end else begin
         want = expected_responses.pop_front();
         check_field("found", 32'(want.found), 32'(rsp_tuser[0]));
         check_field("table_full", 32'(want.table_full), 32'(rsp_tuser[1]));
         check_field("out_time", want.ev.ev_time, rsp_tdata[31:0]);
         check_field("out_kind", 32'(want.ev.kind), 32'(rsp_tdata[34:32]));
         check_field("out_channel", 32'(want.ev.channel), 32'(rsp_tdata[38:35]));
         check_field("out_key", 32'(want.ev.key), 32'(rsp_tdata[45:39]));
         check_field("out_velocity", 32'(want.ev.velocity), 32'(rsp_tdata[52:46]));
         check_field("last", 32'(want.last), 32'(rsp_tlast));
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         // a response always belongs to an earlier request
         if (rsp_tvalid && rsp_tready)
            compare_response();
         if (req_tvalid && req_tready)
            predict_request(req_tuser, req_tdata);
      end
      fail_count    <= fails;
      pending_count <= expected_responses.size();
      stored_count  <= stored;
      dropped_count <= dropped;
      query_count   <= queries;
      match_count   <= hit_total;
   end

endmodule

FILE: tb/tb_time_sorted_event_table.sv
module tb_time_sorted_event_table
   import tset_pkg::*;
();

   localparam int DEPTH        = 64;
   localparam int RANDOM_ITEMS = 244;
   // receiver hold-off that backs the block up
   localparam int LONG_HOLD    = 400;

   logic         clock = 1'b0;
   logic         reset = 1'b1;

   // request channel
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // req_type
   logic         req_tuser  = REQ_INSERT;
   // event_time, event_kind, event_channel, event_key, event_velocity,
   // window_start, window_end, zero fill
   logic [119:0] req_tdata  = '0;

   // response channel
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // found, table_full
   logic [1:0]   rsp_tuser;
   // out_time, out_kind, out_channel, out_key, out_velocity, zero fill
   logic [55:0]  rsp_tdata;
   logic         rsp_tlast;

   int fail_count;
   int pending_count;
   int stored_count;
   int dropped_count;
   int query_count;
   int match_count;

   // flags shared between the request and response processes, and the sent count
   bit no_idle      = 1'b0;
   bit hold_request = 1'b0;
   bit hold_active  = 1'b0;
   int items_sent   = 0;

   time_sorted_event_table #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   event_table_checker #(.DEPTH(DEPTH)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tuser     (rsp_tuser),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .stored_count  (stored_count),
      .dropped_count (dropped_count),
      .query_count   (query_count),
      .match_count   (match_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // single reset pulse at the start
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // safety net in case the block hangs
   initial begin
      #50_000_000;
      $display("FAIL");
      $finish;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // clustered times so that duplicates and window hits are common
   function automatic logic [31:0] pick_stamp();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0)
         return 32'h0000_0000;
      if (roll == 1)
         return 32'hFFFF_FFFF;
      if (roll < 6)
         return $urandom;
      if ($urandom_range(0, 3) == 0)
         return $urandom_range(0, 48) * 256 + $urandom_range(0, 255);
      return $urandom_range(0, 48) * 256;
   endfunction

   function automatic entry_type make_event(input logic [31:0] stamp);
      entry_type ev;
      ev.ev_time  = stamp;
      ev.kind     = 3'($urandom_range(0, 7));
      ev.channel  = 4'($urandom_range(0, 15));
      ev.key      = 7'($urandom_range(0, 127));
      ev.velocity = 7'($urandom_range(0, 127));
      return ev;
   endfunction

   function automatic logic [119:0] pack_request(input entry_type ev,
                                                 input logic [31:0] win_lo,
                                                 input logic [31:0] win_hi);
      return {3'b000, win_hi, win_lo, ev.velocity, ev.key, ev.channel, ev.kind,
              ev.ev_time};
   endfunction

   // valid stays high across back-to-back requests
   task automatic send_request(input logic kind, input logic [119:0] payload);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= payload;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      items_sent++;
   endtask

   // unused window fields carry random bits too
   task automatic send_insert(input entry_type ev);
      send_request(REQ_INSERT, pack_request(ev, $urandom, $urandom));
   endtask

   task automatic send_query(input logic [31:0] win_lo, input logic [31:0] win_hi);
      send_request(REQ_QUERY, pack_request(make_event($urandom), win_lo, win_hi));
   endtask

   task automatic send_random_query();
      logic [31:0] win_lo;
      logic [31:0] win_hi;
      int          roll;
      roll = $urandom_range(0, 9);
      win_lo = pick_stamp();
      if (roll == 0) begin
         win_lo = $urandom;
         win_hi = $urandom;
      end else if (roll == 1) begin
         win_lo = 32'h0000_0000;
         win_hi = 32'hFFFF_FFFF;
      end else if (roll == 2) begin
         win_hi = win_lo;
      end else if (roll == 3) begin
         // start past end, unless the subtraction wraps below zero
         win_hi = win_lo - $urandom_range(1, 500);
      end else begin
         win_hi = win_lo + $urandom_range(0, 3000);
      end
      send_query(win_lo, win_hi);
   endtask

   // response side: random ready stretches, one long hold-off on request
   initial begin
      int gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_active  = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_active  = 1'b0;
         end else if (no_idle) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // request side and verdict
   initial begin
      wait (!reset);
      @(posedge clock);

      // empty table answers with a single no-match
      send_query(32'h0000_0000, 32'hFFFF_FFFF);
      // extremes of every event field
      send_insert('{32'h0000_0000, 3'd0, 4'd0, 7'd0, 7'd0});
      send_insert('{32'hFFFF_FFFF, 3'd7, 4'd15, 7'd127, 7'd127});
      // equal times: each newer one lands in front
      send_insert('{32'd100, 3'd1, 4'd1, 7'd11, 7'd21});
      send_insert('{32'd100, 3'd2, 4'd2, 7'd12, 7'd22});
      send_insert('{32'd100, 3'd3, 4'd3, 7'd13, 7'd23});
      send_insert('{32'd99, 3'd4, 4'd4, 7'd14, 7'd24});
      send_insert('{32'd101, 3'd5, 4'd5, 7'd15, 7'd25});
      send_query(32'd100, 32'd100);
      send_query(32'h0000_0000, 32'h0000_0000);
      send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // start above end never matches
      send_query(32'd200, 32'd100);
      send_query(32'hFFFF_FFFF, 32'h0000_0000);
      // window falling between stored times
      send_query(32'd102, 32'd1000);
      send_query(32'd99, 32'd101);
      send_query(32'h0000_0000, 32'hFFFF_FFFF);

      // random mix: inserts dominate until the table fills, then refused
      // inserts and queries over a full table
      for (int idx = 0; idx < RANDOM_ITEMS; idx++) begin
         if (idx == 30) begin
            // receiver stops; keep offering until the block backs up
            hold_request = 1'b1;
            wait (hold_active);
         end
         no_idle = (idx >= 30 && idx < 50) || (idx >= 150 && idx < 180);
         if ($urandom_range(0, 99) < ((idx < 110) ? 70 : 45))
            send_insert(make_event(pick_stamp()));
         else
            send_random_query();
      end
      no_idle = 1'b0;
      req_tvalid <= 1'b0;

      // drain every outstanding response, then let the block settle
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);

      $display("sent %0d requests: %0d events stored, %0d inserts refused as full",
               items_sent, stored_count, dropped_count);
      $display("%0d window queries returned %0d matching events",
               query_count, match_count);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
